>>> hdl/psbrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psbrd_pkg: shared types and constants for the burst rate detector
// Field widths, register indexes, reset values and the slot layout.
// ----------------------------------------------------------------------------
package psbrd_pkg;

  localparam int unsigned SOURCE_W    = 32;
  localparam int unsigned TIME_W      = 63;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned WINDOW_W    = 40;
  localparam int unsigned THRESHOLD_W = 16;

  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam int unsigned SLOT_COUNT_DEF = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ALERT_THRESHOLD = CFG_INDEX_W'(1);

  localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = WINDOW_W'(50000000);
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(200);
  localparam logic [COUNT_W-1:0]     COUNT_MAX       = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    logic [COUNT_W-1:0]  count;
    logic [TIME_W-1:0]   start;
    logic                alerted;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

>>> hdl/psbrd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psbrd_event_if / psbrd_result_if: valid/ready channels of the detector
// One transfer moves one event item or one result item.
// ----------------------------------------------------------------------------
interface psbrd_event_if;
  import psbrd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SOURCE_W-1:0] source_id;
  logic [TIME_W-1:0]   timestamp;

  modport source (output valid, output source_id, output timestamp, input ready);
  modport sink   (input valid, input source_id, input timestamp, output ready);
endinterface

interface psbrd_result_if;
  import psbrd_pkg::*;

  logic                valid;
  logic                ready;
  logic                alert;
  logic [SOURCE_W-1:0] alert_source;
  logic [COUNT_W-1:0]  event_count;
  logic                new_entry;

  modport source (output valid, output alert, output alert_source, output event_count,
                  output new_entry, input ready);
  modport sink   (input valid, input alert, input alert_source, input event_count,
                  input new_entry, output ready);
endinterface

`default_nettype wire

>>> hdl/psbrd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psbrd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psbrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/per_source_burst_rate_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_burst_rate_detector: per-source fixed-window event rate counter
// Tracks event counts per source id in a slot table and flags bursts.
// ----------------------------------------------------------------------------
// events (sink): one transfer carries source_id and timestamp. results
// (source): one transfer per event with alert, alert_source, event_count and
// new_entry. cfg_write/cfg_index/cfg_data: index 0 window_length, index 1
// alert_threshold, other indexes drop; write only while the block is idle.
// Scan: a miss reads every slot of the table before it claims one, a hit stops
// the scan at the matching slot, and a zero source id skips the scan. The scan
// reads one slot a cycle from the slot RAM; events.ready is high only while
// the sequencer idles, so the next transfer can come in the cycle after the
// result is loaded.
// Stall: the output register holds its result until the receiver takes it; the
// next event is still accepted and scanned, and its result waits in RESULT,
// with events.ready low, until the output register frees up.
// Reset: rst (synchronous) empties the slot table by clearing the fill count,
// restores the register defaults and drops any pending result.
// ----------------------------------------------------------------------------
module per_source_burst_rate_detector #(
  parameter int unsigned SLOT_COUNT = psbrd_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  psbrd_event_if.sink                            events,
  psbrd_result_if.source                         results,
  input  wire logic                              cfg_write,
  input  wire logic [psbrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [psbrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import psbrd_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = IW + 1;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_MISS    = 6'b000100,
    ST_HIT_CHK = 6'b001000,
    ST_HIT_UPD = 6'b010000,
    ST_RESULT  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [WINDOW_W-1:0]    window_length;
  logic [THRESHOLD_W-1:0] alert_threshold;

  // Current event.
  logic [SOURCE_W-1:0] cur_id;
  logic [TIME_W-1:0]   cur_time;

  // Scan control: issue address and the slot whose read data is now valid.
  logic [CW-1:0] scan_addr;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic          rd_vld;
  logic          issue;

  // Fill count: slots are claimed in index order and never freed, so the
  // slots below the count are in use and the rest read as free.
  logic [CW-1:0] fill_count;

  // Miss trackers.
  logic              have_free;
  logic [IW-1:0]     free_idx;
  logic [IW-1:0]     min_idx;
  logic [TIME_W-1:0] min_start;

  // Captured hit entry.
  logic [IW-1:0]      hit_idx;
  logic [COUNT_W-1:0] hit_count;
  logic [TIME_W-1:0]  hit_start;
  logic               hit_alerted;
  logic               expired;

  // Pending result.
  logic                res_alert;
  logic [SOURCE_W-1:0] res_source;
  logic [COUNT_W-1:0]  res_count;
  logic                res_new;

  // RAM ports.
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  slot_t             wr_slot;
  logic [SLOT_W-1:0] rd_data;
  slot_t             rd_slot;

  // Combinational helpers.
  logic               accept;
  logic               is_hit;
  logic               last_slot;
  logic [TIME_W:0]    diff;
  logic [COUNT_W-1:0] upd_count;
  logic [TIME_W-1:0]  upd_start;
  logic               upd_alerted_old;
  logic               upd_alert;
  logic               out_free;

  assign accept    = events.valid && events.ready;
  assign events.ready = (state == ST_IDLE);
  assign issue     = (state == ST_SCAN) && (scan_addr < CW'(SLOT_COUNT));
  assign rd_slot   = slot_t'(rd_data);
  assign is_hit    = rd_pend && rd_vld && (rd_slot.source == cur_id);
  assign last_slot = (rd_idx == IW'(SLOT_COUNT - 1));
  assign out_free  = !results.valid || results.ready;

  // Window check: signed difference now - start against the window length.
  assign diff = {1'b0, cur_time} - {1'b0, hit_start};

  // Hit update: restart an expired window, else count up and saturate.
  always_comb begin
    if (expired) begin
      upd_count       = COUNT_W'(1);
      upd_start       = cur_time;
      upd_alerted_old = 1'b0;
    end else begin
      upd_count       = (hit_count != COUNT_MAX) ? hit_count + COUNT_W'(1) : hit_count;
      upd_start       = hit_start;
      upd_alerted_old = hit_alerted;
    end
    upd_alert = !upd_alerted_old && (upd_count >= alert_threshold);
  end

  // Slot RAM write: claim on a miss, update on a hit.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx;
    wr_slot = '{source: cur_id, count: upd_count, start: upd_start,
                alerted: upd_alerted_old || upd_alert};
    if (state == ST_MISS) begin
      wr_en   = 1'b1;
      wr_addr = have_free ? free_idx : min_idx;
      wr_slot = '{source: cur_id, count: COUNT_W'(1), start: cur_time, alerted: 1'b0};
    end else if (state == ST_HIT_UPD) begin
      wr_en   = 1'b1;
    end
  end

  psbrd_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (issue),
    .rd_addr (scan_addr[IW-1:0]),
    .rd_data (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_RESET;
      alert_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:   window_length   <= cfg_data[WINDOW_W-1:0];
        REG_ALERT_THRESHOLD: alert_threshold <= cfg_data[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Fill count: advance on every claim of a free slot, clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (state == ST_MISS && have_free) begin
      fill_count <= fill_count + CW'(1);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_id    <= events.source_id;
            cur_time  <= events.timestamp;
            scan_addr <= '0;
            rd_pend   <= 1'b0;
            have_free <= 1'b0;
            if (events.source_id == '0) begin
              // Zero id: leave the table alone, answer with all zeros.
              res_alert  <= 1'b0;
              res_source <= '0;
              res_count  <= '0;
              res_new    <= 1'b0;
              state      <= ST_RESULT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Advance the read address; data for rd_idx arrives in the cycle after the read.
          if (issue) begin
            scan_addr <= scan_addr + CW'(1);
            rd_idx    <= scan_addr[IW-1:0];
            rd_vld    <= (scan_addr < fill_count);
          end
          rd_pend <= issue && !is_hit;
          if (rd_pend) begin
            if (is_hit) begin
              hit_idx     <= rd_idx;
              hit_count   <= rd_slot.count;
              hit_start   <= rd_slot.start;
              hit_alerted <= rd_slot.alerted;
              state       <= ST_HIT_CHK;
            end else begin
              if (!rd_vld && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= rd_idx;
              end
              // Oldest start, ties to the lowest index (strict compare).
              if (rd_idx == '0 || rd_slot.start < min_start) begin
                min_idx   <= rd_idx;
                min_start <= rd_slot.start;
              end
              if (last_slot) begin
                state   <= ST_MISS;
              end
            end
          end
        end
        ST_MISS: begin
          res_alert  <= 1'b0;
          res_source <= cur_id;
          res_count  <= COUNT_W'(1);
          res_new    <= 1'b1;
          state      <= ST_RESULT;
        end
        ST_HIT_CHK: begin
          expired <= !diff[TIME_W] &&
                     (diff[TIME_W-1:0] > {{(TIME_W - WINDOW_W){1'b0}}, window_length});
          state   <= ST_HIT_UPD;
        end
        ST_HIT_UPD: begin
          res_alert  <= upd_alert;
          res_source <= cur_id;
          res_count  <= upd_count;
          res_new    <= 1'b0;
          state      <= ST_RESULT;
        end
        ST_RESULT: begin
          // Hold until the output register is empty or being drained.
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      results.valid        <= 1'b1;
      results.alert        <= res_alert;
      results.alert_source <= res_source;
      results.event_count  <= res_count;
      results.new_entry    <= res_new;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
